/* src/dq_current_pi_controller_defines.svh */
// Assertion macros for the dq current PI controller.
// Used by the top level only; depends on nothing else.
`ifndef DQ_CURRENT_PI_CONTROLLER_DEFINES_SVH
`define DQ_CURRENT_PI_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DQPI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dqpi: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DQPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dqpi: next-cycle check failed");

`endif

/* src/dqpi_pkg.sv */
// Shared types and constants of the dq current PI controller.
// Used by every module of the block; depends on nothing.
package dqpi_pkg;

   localparam int GAIN_FRACTION_BITS_DEFAULT = 20;
   localparam int SAMPLE_WIDTH_DEFAULT       = 16;

   localparam int GAIN_W     = 24;
   localparam int LIMIT_W    = 15;
   localparam int DECAY_W    = 16;
   localparam int INTEG_W    = 32;
   localparam int MUL_W      = 32;
   localparam int DEN_W      = 32;
   localparam int SQ_W       = 62;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;

   localparam logic [GAIN_W-1:0]  KP_RESET    = 24'd7485;
   localparam logic [GAIN_W-1:0]  KI_RESET    = 24'd5290;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd22702;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd64881;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROPORTIONAL_GAIN,
      CSR_INTEGRAL_GAIN_STEP,
      CSR_DUTY_LIMIT,
      CSR_WINDUP_DECAY
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_PD, ST_PQ, ST_VQ,
      ST_DVD_GO, ST_DVD_WAIT, ST_DVQ_GO, ST_DVQ_WAIT,
      ST_NORM, ST_SQD, ST_SQQ, ST_SQL, ST_CMP,
      ST_SQRT_GO, ST_SQRT_WAIT,
      ST_SCD, ST_SCD_GO, ST_SCD_WAIT, ST_SCQ, ST_SCQ_GO, ST_SCQ_WAIT,
      ST_DCD, ST_DCQ, ST_DC_END,
      ST_ITD, ST_ITQ, ST_IT_END,
      ST_PK1, ST_PK2, ST_PK3, ST_PK4, ST_PK5,
      ST_FINISH
   } dqpi_state_type;

endpackage

/* src/dqpi_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on dqpi_pkg for the operand width.
module dqpi_mul (
   input  logic                                  clock,
   input  logic signed [dqpi_pkg::MUL_W-1:0]     mul_a,
   input  logic signed [dqpi_pkg::MUL_W-1:0]     mul_b,
   output logic signed [2*dqpi_pkg::MUL_W-1:0]   mul_p_ff
);

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

endmodule

/* src/dqpi_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on dqpi_pkg for the divisor width.
module dqpi_div #(
   parameter int NUM_W = dqpi_pkg::SAMPLE_WIDTH_DEFAULT + 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NUM_W-1:0]              num,
   input  logic [dqpi_pkg::DEN_W-1:0]    den,
   output logic                          busy,
   output logic [NUM_W-1:0]              quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam int DW    = dqpi_pkg::DEN_W;

   logic [DW-1:0]    rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DW:0]      trial, diff;
   logic             ge;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

/* src/dqpi_sqrt.sv */
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on dqpi_pkg for the radicand width.
module dqpi_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dqpi_pkg::SQ_W-1:0]         radicand,
   output logic                              busy,
   output logic [dqpi_pkg::SQ_W/2-1:0]       root
);

   localparam int W = dqpi_pkg::SQ_W;

   logic [W-1:0] x_ff, x_in, r_ff, r_in, b_ff, b_in;
   logic         busy_ff, busy_in;
   logic [W:0]   trial;
   logic         ge;

   assign trial = {1'b0, r_ff} + {1'b0, b_ff};
   assign ge    = {1'b0, x_ff} >= trial;

   always_comb begin
      x_in    = x_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = radicand;
         r_in    = '0;
         b_in    = W'(1) << (W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            x_in = x_ff - trial[W-1:0];
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in    = b_ff >> 2;
         busy_in = !b_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff <= x_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign busy = busy_ff;
   assign root = r_ff[W/2-1:0];

endmodule

/* src/dq_current_pi_controller.sv */
// dq-axis current PI controller: sequencer, datapath registers and assertions.
// Depends on dqpi_pkg, dqpi_mul, dqpi_div, dqpi_sqrt and the defines header.
//
// Use: one word on the req_ channel carries a mode, the q current target, the
// measured d and q currents, the bus voltage and the sine and cosine of the
// electrical angle. Each accepted word gives exactly one word on the rsp_
// channel: alpha and beta duty commands and a limiting flag. Mode 1 clears
// both integrators and answers with zero duties and a clear limiting flag.
// A control step runs on one shared multiplier, one restoring divider (one bit
// per cycle) and one square-root unit. An unlimited step runs two divisions;
// a limited step adds two more divisions, the root, two more multiplier
// products and the halving of the duties where needed. A zero bus voltage
// answers with zero duties and the limiting flag set. req_ready is high only
// while the sequencer is idle, so a new word is taken once the previous one
// has been handed to the output register, even if that register is still
// waiting for rsp_ready.
// When the receiver stalls, the result holds in the output register and the
// next step finishes its work and waits before its own result is written.
// The csr_ port is always ready; write only while the block is idle.
// Reset (synchronous) restores the register defaults, zeroes the integrators,
// drops rsp_valid and returns the sequencer to idle.
`include "dq_current_pi_controller_defines.svh"

module dq_current_pi_controller #(
   parameter int GAIN_FRACTION_BITS = dqpi_pkg::GAIN_FRACTION_BITS_DEFAULT,
   parameter int SAMPLE_WIDTH       = dqpi_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_ref_current,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_d_current,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_q_current,
   input  logic        [SAMPLE_WIDTH-1:0]        req_bus_voltage,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sine_angle,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_cosine_angle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_alpha_duty,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_beta_duty,
   output logic                                  rsp_limiting,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dqpi_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dqpi_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int SW         = SAMPLE_WIDTH;
   localparam int GSHIFT     = GAIN_FRACTION_BITS - 8;
   localparam int ERR_W      = SW + 1;
   localparam int SUM_W      = SW + 30;
   localparam int VOLT_W     = 42;
   localparam int NUM_W      = SW + 32;
   localparam int DD_W       = NUM_W + 1;
   localparam int PARK_W     = 2 * SW + 1;
   localparam int MW         = dqpi_pkg::MUL_W;
   localparam int PROD_W     = 2 * MW;
   localparam int IW         = dqpi_pkg::INTEG_W;
   localparam int DUTY_SHIFT = SW - 10;
   localparam int LIM_SHL    = (SW >= 16) ? SW - 16 : 0;
   localparam int LIM_SHR    = (SW < 16) ? 16 - SW : 0;

   localparam logic signed [SUM_W-1:0]  VOLT_MAX = SUM_W'(64'sd1099511627776);
   localparam logic signed [SUM_W-1:0]  I32_MAX  = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0]  I32_MIN  = SUM_W'(-64'sd2147483648);
   localparam logic signed [DD_W-1:0]   NORM_MAX = DD_W'(64'sd1073741824);
   localparam logic signed [PARK_W-1:0] OUT_MAX  =
      PARK_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [PARK_W-1:0] OUT_MIN  = -OUT_MAX - PARK_W'(1);

   // Configuration registers.
   logic [dqpi_pkg::GAIN_W-1:0]  kp_ff, ki_ff;
   logic [dqpi_pkg::LIMIT_W-1:0] dlim_ff;
   logic [dqpi_pkg::DECAY_W-1:0] decay_ff;

   // Sequencer and datapath registers.
   dqpi_pkg::dqpi_state_type state_ff, state_in;
   logic signed [ERR_W-1:0]  derr_ff, derr_in, qerr_ff, qerr_in;
   logic signed [SW-1:0]     sin_ff, sin_in, cos_ff, cos_in;
   logic [SW-1:0]            vbus_ff, vbus_in;
   logic signed [IW-1:0]     integ_d_ff, integ_d_in, integ_q_ff, integ_q_in;
   logic signed [VOLT_W-1:0] vd_ff, vd_in, vq_ff, vq_in;
   logic signed [DD_W-1:0]   dd_ff, dd_in, dq_ff, dq_in;
   logic [dqpi_pkg::SQ_W-1:0] sum_ff, sum_in;
   logic [dqpi_pkg::DEN_W-1:0] mag_ff, mag_in;
   logic                     div_neg_ff, div_neg_in;
   logic                     lim_flag_ff, lim_flag_in;
   logic signed [PARK_W-1:0] park_ff, park_in;
   logic signed [SW-1:0]     res_alpha_ff, res_alpha_in, res_beta_ff, res_beta_in;
   logic                     res_lim_ff, res_lim_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]     rsp_alpha_ff, rsp_alpha_in, rsp_beta_ff, rsp_beta_in;
   logic                     rsp_lim_ff, rsp_lim_in;

   // Shared units.
   logic signed [MW-1:0]     mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic                     div_start, div_busy;
   logic [NUM_W-1:0]         div_num, div_quo;
   logic [dqpi_pkg::DEN_W-1:0] div_den;
   logic                     sqrt_start, sqrt_busy;
   logic [dqpi_pkg::SQ_W/2-1:0] sqrt_root;

   // Helper terms.
   logic signed [SUM_W-1:0]  gterm, vsum;
   logic signed [IW-1:0]     integ_sel, decay_val;
   logic signed [VOLT_W-1:0] vsel;
   logic signed [DD_W-1:0]   n3, nscaled, quo_signed;
   logic                     duty_neg, scale_neg, dd_big, dq_big;
   logic [NUM_W-1:0]         duty_mag, scale_mag;
   logic [MW-1:0]            lim_u;
   logic signed [MW-1:0]     lim_s, kp_s, ki_s, decay_s;
   logic signed [PARK_W-1:0] park_diff, park_sum;
   logic signed [ERR_W-1:0]  acc_derr, acc_qerr;

   function automatic logic signed [VOLT_W-1:0] clamp_volt(
      input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] c;
      c = v;
      if (v > VOLT_MAX) c = VOLT_MAX;
      else if (v < -VOLT_MAX) c = -VOLT_MAX;
      return VOLT_W'(c);
   endfunction

   function automatic logic signed [IW-1:0] sat_integ(
      input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] c;
      c = v;
      if (v > I32_MAX) c = I32_MAX;
      else if (v < I32_MIN) c = I32_MIN;
      return IW'(c);
   endfunction

   function automatic logic signed [SW-1:0] sat_out(
      input logic signed [PARK_W-1:0] v);
      logic signed [PARK_W-1:0] s;
      s = v >>> (SW - 1);
      if (s > OUT_MAX) s = OUT_MAX;
      else if (s < OUT_MIN) s = OUT_MIN;
      return SW'(s);
   endfunction

   dqpi_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_p_ff (mul_p)
   );

   dqpi_div #(.NUM_W(NUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   dqpi_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sum_ff),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   // Gain product with eight fraction bits (Q38.8 at the default width), added to the integrator of the axis in hand.
   assign gterm     = SUM_W'(mul_p >>> GSHIFT);
   assign integ_sel = (state_ff == dqpi_pkg::ST_VQ || state_ff == dqpi_pkg::ST_IT_END) ?
                      integ_q_ff : integ_d_ff;
   assign vsum      = gterm + SUM_W'(integ_sel);

   // Duty numerator 3 * v * 2^(SW-10), split into sign and magnitude.
   assign vsel     = (state_ff == dqpi_pkg::ST_DVD_GO) ? vd_ff : vq_ff;
   assign n3       = (DD_W'(vsel) <<< 1) + DD_W'(vsel);
   assign nscaled  = n3 <<< DUTY_SHIFT;
   assign duty_neg = nscaled[DD_W-1];
   assign duty_mag = NUM_W'(duty_neg ? -nscaled : nscaled);

   // Scale numerator duty * limit comes straight from the multiplier.
   assign scale_neg = mul_p[PROD_W-1];
   assign scale_mag = NUM_W'(scale_neg ? -mul_p : mul_p);

   assign quo_signed = div_neg_ff ? -$signed(DD_W'(div_quo)) : $signed(DD_W'(div_quo));
   assign decay_val  = IW'(mul_p >>> dqpi_pkg::DECAY_W);

   assign lim_u   = (MW'(dlim_ff) << LIM_SHL) >> LIM_SHR;
   assign lim_s   = $signed(lim_u);
   assign kp_s    = $signed(MW'(kp_ff));
   assign ki_s    = $signed(MW'(ki_ff));
   assign decay_s = $signed(MW'(decay_ff));

   assign dd_big = (dd_ff >= NORM_MAX) || (dd_ff <= -NORM_MAX);
   assign dq_big = (dq_ff >= NORM_MAX) || (dq_ff <= -NORM_MAX);

   assign park_diff = park_ff - PARK_W'(mul_p);
   assign park_sum  = park_ff + PARK_W'(mul_p);

   assign acc_derr = -ERR_W'(req_d_current);
   assign acc_qerr = ERR_W'(req_ref_current) - ERR_W'(req_q_current);

   assign div_num = (state_ff == dqpi_pkg::ST_DVD_GO || state_ff == dqpi_pkg::ST_DVQ_GO) ?
                    duty_mag : scale_mag;
   assign div_den = (state_ff == dqpi_pkg::ST_DVD_GO || state_ff == dqpi_pkg::ST_DVQ_GO) ?
                    dqpi_pkg::DEN_W'(vbus_ff) : mag_ff;

   // Next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      derr_in      = derr_ff;
      qerr_in      = qerr_ff;
      sin_in       = sin_ff;
      cos_in       = cos_ff;
      vbus_in      = vbus_ff;
      integ_d_in   = integ_d_ff;
      integ_q_in   = integ_q_ff;
      vd_in        = vd_ff;
      vq_in        = vq_ff;
      dd_in        = dd_ff;
      dq_in        = dq_ff;
      sum_in       = sum_ff;
      mag_in       = mag_ff;
      div_neg_in   = div_neg_ff;
      lim_flag_in  = lim_flag_ff;
      park_in      = park_ff;
      res_alpha_in = res_alpha_ff;
      res_beta_in  = res_beta_ff;
      res_lim_in   = res_lim_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_alpha_in = rsp_alpha_ff;
      rsp_beta_in  = rsp_beta_ff;
      rsp_lim_in   = rsp_lim_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;
      req_ready    = 1'b0;

      unique case (state_ff)
         dqpi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               derr_in     = acc_derr;
               qerr_in     = acc_qerr;
               sin_in      = req_sine_angle;
               cos_in      = req_cosine_angle;
               vbus_in     = req_bus_voltage;
               lim_flag_in = 1'b0;
               res_alpha_in = '0;
               res_beta_in  = '0;
               res_lim_in   = 1'b0;
               if (req_mode) begin
                  integ_d_in = '0;
                  integ_q_in = '0;
                  state_in   = dqpi_pkg::ST_FINISH;
               end else if (req_bus_voltage == '0) begin
                  res_lim_in = 1'b1;
                  state_in   = dqpi_pkg::ST_FINISH;
               end else begin
                  state_in = dqpi_pkg::ST_PD;
               end
            end
         end
         dqpi_pkg::ST_PD: begin
            mul_a    = MW'(derr_ff);
            mul_b    = kp_s;
            state_in = dqpi_pkg::ST_PQ;
         end
         dqpi_pkg::ST_PQ: begin
            mul_a    = MW'(qerr_ff);
            mul_b    = kp_s;
            vd_in    = clamp_volt(vsum);
            state_in = dqpi_pkg::ST_VQ;
         end
         dqpi_pkg::ST_VQ: begin
            vq_in    = clamp_volt(vsum);
            state_in = dqpi_pkg::ST_DVD_GO;
         end
         dqpi_pkg::ST_DVD_GO: begin
            div_start  = 1'b1;
            div_neg_in = duty_neg;
            state_in   = dqpi_pkg::ST_DVD_WAIT;
         end
         dqpi_pkg::ST_DVD_WAIT: begin
            if (!div_busy) begin
               dd_in    = quo_signed;
               state_in = dqpi_pkg::ST_DVQ_GO;
            end
         end
         dqpi_pkg::ST_DVQ_GO: begin
            div_start  = 1'b1;
            div_neg_in = duty_neg;
            state_in   = dqpi_pkg::ST_DVQ_WAIT;
         end
         dqpi_pkg::ST_DVQ_WAIT: begin
            if (!div_busy) begin
               dq_in    = quo_signed;
               state_in = dqpi_pkg::ST_NORM;
            end
         end
         dqpi_pkg::ST_NORM: begin
            // Halve both duties together until each magnitude is below 2^30.
            if (dd_big || dq_big) begin
               dd_in       = dd_ff >>> 1;
               dq_in       = dq_ff >>> 1;
               lim_flag_in = 1'b1;
            end else begin
               state_in = dqpi_pkg::ST_SQD;
            end
         end
         dqpi_pkg::ST_SQD: begin
            mul_a    = MW'(dd_ff);
            mul_b    = MW'(dd_ff);
            state_in = dqpi_pkg::ST_SQQ;
         end
         dqpi_pkg::ST_SQQ: begin
            mul_a    = MW'(dq_ff);
            mul_b    = MW'(dq_ff);
            sum_in   = dqpi_pkg::SQ_W'(mul_p);
            state_in = dqpi_pkg::ST_SQL;
         end
         dqpi_pkg::ST_SQL: begin
            mul_a    = lim_s;
            mul_b    = lim_s;
            sum_in   = sum_ff + dqpi_pkg::SQ_W'(mul_p);
            state_in = dqpi_pkg::ST_CMP;
         end
         dqpi_pkg::ST_CMP: begin
            if (lim_flag_ff || (sum_ff > dqpi_pkg::SQ_W'(mul_p))) begin
               lim_flag_in = 1'b1;
               state_in    = dqpi_pkg::ST_SQRT_GO;
            end else begin
               state_in = dqpi_pkg::ST_ITD;
            end
         end
         dqpi_pkg::ST_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = dqpi_pkg::ST_SQRT_WAIT;
         end
         dqpi_pkg::ST_SQRT_WAIT: begin
            if (!sqrt_busy) begin
               // A zero magnitude is taken as one.
               mag_in   = (sqrt_root == '0) ? dqpi_pkg::DEN_W'(1) :
                          dqpi_pkg::DEN_W'(sqrt_root);
               state_in = dqpi_pkg::ST_SCD;
            end
         end
         dqpi_pkg::ST_SCD: begin
            mul_a    = MW'(dd_ff);
            mul_b    = lim_s;
            state_in = dqpi_pkg::ST_SCD_GO;
         end
         dqpi_pkg::ST_SCD_GO: begin
            div_start  = 1'b1;
            div_neg_in = scale_neg;
            state_in   = dqpi_pkg::ST_SCD_WAIT;
         end
         dqpi_pkg::ST_SCD_WAIT: begin
            if (!div_busy) begin
               dd_in    = quo_signed;
               state_in = dqpi_pkg::ST_SCQ;
            end
         end
         dqpi_pkg::ST_SCQ: begin
            mul_a    = MW'(dq_ff);
            mul_b    = lim_s;
            state_in = dqpi_pkg::ST_SCQ_GO;
         end
         dqpi_pkg::ST_SCQ_GO: begin
            div_start  = 1'b1;
            div_neg_in = scale_neg;
            state_in   = dqpi_pkg::ST_SCQ_WAIT;
         end
         dqpi_pkg::ST_SCQ_WAIT: begin
            if (!div_busy) begin
               dq_in    = quo_signed;
               state_in = dqpi_pkg::ST_DCD;
            end
         end
         dqpi_pkg::ST_DCD: begin
            mul_a    = integ_d_ff;
            mul_b    = decay_s;
            state_in = dqpi_pkg::ST_DCQ;
         end
         dqpi_pkg::ST_DCQ: begin
            mul_a      = integ_q_ff;
            mul_b      = decay_s;
            integ_d_in = decay_val;
            state_in   = dqpi_pkg::ST_DC_END;
         end
         dqpi_pkg::ST_DC_END: begin
            integ_q_in = decay_val;
            state_in   = dqpi_pkg::ST_PK1;
         end
         dqpi_pkg::ST_ITD: begin
            mul_a    = MW'(derr_ff);
            mul_b    = ki_s;
            state_in = dqpi_pkg::ST_ITQ;
         end
         dqpi_pkg::ST_ITQ: begin
            mul_a      = MW'(qerr_ff);
            mul_b      = ki_s;
            integ_d_in = sat_integ(vsum);
            state_in   = dqpi_pkg::ST_IT_END;
         end
         dqpi_pkg::ST_IT_END: begin
            integ_q_in = sat_integ(vsum);
            state_in   = dqpi_pkg::ST_PK1;
         end
         dqpi_pkg::ST_PK1: begin
            mul_a    = MW'(dd_ff);
            mul_b    = MW'(cos_ff);
            state_in = dqpi_pkg::ST_PK2;
         end
         dqpi_pkg::ST_PK2: begin
            mul_a    = MW'(dq_ff);
            mul_b    = MW'(sin_ff);
            park_in  = PARK_W'(mul_p);
            state_in = dqpi_pkg::ST_PK3;
         end
         dqpi_pkg::ST_PK3: begin
            mul_a        = MW'(dd_ff);
            mul_b        = MW'(sin_ff);
            res_alpha_in = sat_out(park_diff);
            state_in     = dqpi_pkg::ST_PK4;
         end
         dqpi_pkg::ST_PK4: begin
            mul_a    = MW'(dq_ff);
            mul_b    = MW'(cos_ff);
            park_in  = PARK_W'(mul_p);
            state_in = dqpi_pkg::ST_PK5;
         end
         dqpi_pkg::ST_PK5: begin
            res_beta_in = sat_out(park_sum);
            res_lim_in  = lim_flag_ff;
            state_in    = dqpi_pkg::ST_FINISH;
         end
         dqpi_pkg::ST_FINISH: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_alpha_in = res_alpha_ff;
               rsp_beta_in  = res_beta_ff;
               rsp_lim_in   = res_lim_ff;
               state_in     = dqpi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dqpi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dqpi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_d_ff   <= '0;
         integ_q_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         integ_d_ff   <= integ_d_in;
         integ_q_ff   <= integ_q_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      derr_ff      <= derr_in;
      qerr_ff      <= qerr_in;
      sin_ff       <= sin_in;
      cos_ff       <= cos_in;
      vbus_ff      <= vbus_in;
      vd_ff        <= vd_in;
      vq_ff        <= vq_in;
      dd_ff        <= dd_in;
      dq_ff        <= dq_in;
      sum_ff       <= sum_in;
      mag_ff       <= mag_in;
      div_neg_ff   <= div_neg_in;
      lim_flag_ff  <= lim_flag_in;
      park_ff      <= park_in;
      res_alpha_ff <= res_alpha_in;
      res_beta_ff  <= res_beta_in;
      res_lim_ff   <= res_lim_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_beta_ff  <= rsp_beta_in;
      rsp_lim_ff   <= rsp_lim_in;
   end

   // Register writes; only the low bits of each register's width are kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= dqpi_pkg::KP_RESET;
         ki_ff    <= dqpi_pkg::KI_RESET;
         dlim_ff  <= dqpi_pkg::LIMIT_RESET;
         decay_ff <= dqpi_pkg::DECAY_RESET;
      end else if (csr_valid) begin
         unique case (dqpi_pkg::csr_index_type'(csr_index))
            dqpi_pkg::CSR_PROPORTIONAL_GAIN:  kp_ff    <= csr_data;
            dqpi_pkg::CSR_INTEGRAL_GAIN_STEP: ki_ff    <= csr_data;
            dqpi_pkg::CSR_DUTY_LIMIT:         dlim_ff  <= csr_data[dqpi_pkg::LIMIT_W-1:0];
            dqpi_pkg::CSR_WINDUP_DECAY:       decay_ff <= csr_data[dqpi_pkg::DECAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alpha_duty = rsp_alpha_ff;
   assign rsp_beta_duty  = rsp_beta_ff;
   assign rsp_limiting   = rsp_lim_ff;

   // The sequencer leaves idle on every accepted word.
   `DQPI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // The divider and root unit are only started when free.
   `DQPI_ASSERT_NOW(a_div_start_free, clock, reset, div_start, !div_busy)
   `DQPI_ASSERT_NOW(a_sqrt_start_free, clock, reset, sqrt_start, !sqrt_busy)

endmodule
